@@ hdl/pef_pkg.sv @@
// Shared types and constants of the postfix expression evaluator.
`timescale 1ns / 1ps

package pef_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ITER_W      = $clog2(DATA_WIDTH);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIN
  } alu_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSHN,
    S_OPCHK,
    S_RDR,
    S_RDL,
    S_EXEC,
    S_TOPRD,
    S_TOPWT,
    S_EMIT
  } pef_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic divz;
  } alu_rsp_t;

endpackage

@@ hdl/pef_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pef_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/pef_alu.sv @@
// Shared arithmetic unit: add, subtract and multiply with a registered result, bit-serial signed divide.
`timescale 1ns / 1ps

module pef_alu (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pef_pkg::alu_req_t              req_i,
  input  logic [pef_pkg::DATA_WIDTH-1:0] a_i,
  input  logic [pef_pkg::DATA_WIDTH-1:0] b_i,
  output pef_pkg::alu_rsp_t              rsp_o,
  output logic [pef_pkg::DATA_WIDTH-1:0] result_o
);

  localparam int unsigned W = pef_pkg::DATA_WIDTH;

  pef_pkg::alu_state_e          state_q, state_d;
  logic                         done_q, done_d;
  logic                         divz_q, divz_d;
  logic                         neg_q, neg_d;
  logic [pef_pkg::ITER_W-1:0]   iter_q, iter_d;
  logic [W-1:0]                 res_q, res_d;
  logic [W-1:0]                 rem_q, rem_d;
  logic [W-1:0]                 quo_q, quo_d;
  logic [W-1:0]                 mb_q, mb_d;
  logic [W:0]                   shifted;
  logic [W:0]                   trial;
  logic [W-1:0]                 mag_a;
  logic [W-1:0]                 mag_b;

  assign mag_a   = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign mag_b   = b_i[W-1] ? (W'(0) - b_i) : b_i;
  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, mb_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pef_pkg::A_IDLE: begin
        if (req_i.start && req_i.op == pef_pkg::OP_DIV && b_i != '0) begin
          state_d = pef_pkg::A_DIV;
        end
      end
      pef_pkg::A_DIV: begin
        if (iter_q == pef_pkg::ITER_W'(W - 1)) begin
          state_d = pef_pkg::A_FIN;
        end
      end
      pef_pkg::A_FIN: state_d = pef_pkg::A_IDLE;
      default:        state_d = pef_pkg::A_IDLE;
    endcase
  end

  always_comb begin
    done_d = 1'b0;
    divz_d = divz_q;
    neg_d  = neg_q;
    iter_d = iter_q;
    res_d  = res_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mb_d   = mb_q;
    unique case (state_q)
      pef_pkg::A_IDLE: begin
        if (req_i.start) begin
          divz_d = 1'b0;
          case (req_i.op)
            pef_pkg::OP_ADD: begin
              res_d  = a_i + b_i;
              done_d = 1'b1;
            end
            pef_pkg::OP_SUB: begin
              res_d  = a_i - b_i;
              done_d = 1'b1;
            end
            pef_pkg::OP_MUL: begin
              res_d  = a_i * b_i;
              done_d = 1'b1;
            end
            default: begin
              if (b_i == '0) begin
                res_d  = '0;
                divz_d = 1'b1;
                done_d = 1'b1;
              end else begin
                neg_d  = a_i[W-1] ^ b_i[W-1];
                rem_d  = '0;
                quo_d  = mag_a;
                mb_d   = mag_b;
                iter_d = '0;
              end
            end
          endcase
        end
      end
      pef_pkg::A_DIV: begin
        if (!trial[W]) begin
          rem_d = trial[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = shifted[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
        iter_d = iter_q + pef_pkg::ITER_W'(1);
      end
      pef_pkg::A_FIN: begin
        res_d  = neg_q ? (W'(0) - quo_q) : quo_q;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pef_pkg::A_IDLE;
      done_q  <= 1'b0;
      divz_q  <= 1'b0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      divz_q  <= divz_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    res_q <= res_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    mb_q  <= mb_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.divz = divz_q;
  assign result_o   = res_q;

endmodule

@@ hdl/postfix_expression_evaluator_unit.sv @@
// Top level of the postfix expression evaluator: character sequencer and operand stack.
`timescale 1ns / 1ps

// Characters arrive one per transfer. A digit is folded into the pending number in the
// cycle it is taken, so runs of digits stream at one character per cycle. Any other
// character first pushes the pending number, and an operator with two operands on
// the stack then reads them one after the other through the stack RAM's single read
// port and runs them through the shared arithmetic unit, whose bit-serial divider
// forms the quotient one bit at a time. The character marked last also pushes any
// pending number, then reads the top of stack and loads the output register before
// the result transfer. The input stays stalled while a character is being worked
// on; a finished result waits in the output register without holding up new
// characters until the next result is to be loaded into it.
module postfix_expression_evaluator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o
);

  localparam int unsigned W = pef_pkg::DATA_WIDTH;
  localparam int unsigned A = pef_pkg::ADDR_W;
  localparam int unsigned C = pef_pkg::CNT_W;
  localparam logic [C-1:0] FULL_CNT = C'(pef_pkg::STACK_DEPTH);

  pef_pkg::pef_state_e state_q, state_d;
  pef_pkg::alu_op_e    op_q, op_d;
  pef_pkg::status_e    err_q, err_d;
  pef_pkg::status_e    status_q, status_d;
  pef_pkg::alu_req_t   alu_req;
  pef_pkg::alu_rsp_t   alu_rsp;

  logic [C-1:0] cnt_q, cnt_d;
  logic [C-1:0] cnt_m1;
  logic [C-1:0] cnt_m2;
  logic [W-1:0] accum_q, accum_d;
  logic         innum_q, innum_d;
  logic         isop_q, isop_d;
  logic         last_q, last_d;
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] r_q, r_d;
  logic [W-1:0] top_q, top_d;
  logic [W-1:0] value_q, value_d;

  logic         ram_we;
  logic [A-1:0] ram_waddr;
  logic [W-1:0] ram_wdata;
  logic         ram_re;
  logic [A-1:0] ram_raddr;
  logic [W-1:0] ram_rdata;
  logic [W-1:0] alu_result;

  logic         is_digit;
  logic         is_op;
  logic [7:0]   digit_raw;
  logic [W-1:0] accum_next;
  logic         can_emit;
  pef_pkg::alu_op_e op_dec;

  assign cnt_m1    = cnt_q - C'(1);
  assign cnt_m2    = cnt_q - C'(2);
  assign is_digit  = (char_code_i >= pef_pkg::CHAR_ZERO) && (char_code_i <= pef_pkg::CHAR_NINE);
  assign digit_raw = char_code_i - pef_pkg::CHAR_ZERO;
  assign accum_next = {accum_q[W-4:0], 3'b000} + {accum_q[W-2:0], 1'b0}
                    + W'(digit_raw[3:0]);
  assign can_emit  = !out_valid_q || !out_stall_i;

  always_comb begin
    is_op  = 1'b1;
    op_dec = pef_pkg::OP_ADD;
    case (char_code_i)
      pef_pkg::CHAR_PLUS:  op_dec = pef_pkg::OP_ADD;
      pef_pkg::CHAR_MINUS: op_dec = pef_pkg::OP_SUB;
      pef_pkg::CHAR_STAR:  op_dec = pef_pkg::OP_MUL;
      pef_pkg::CHAR_SLASH: op_dec = pef_pkg::OP_DIV;
      default:             is_op  = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pef_pkg::S_IDLE: begin
        if (in_valid_i && (!is_digit || last_char_i)) begin
          state_d = pef_pkg::S_PUSHN;
        end
      end
      pef_pkg::S_PUSHN: begin
        if (isop_q) begin
          state_d = pef_pkg::S_OPCHK;
        end else if (last_q) begin
          state_d = pef_pkg::S_TOPRD;
        end else begin
          state_d = pef_pkg::S_IDLE;
        end
      end
      pef_pkg::S_OPCHK: begin
        if (cnt_q >= C'(2)) begin
          state_d = pef_pkg::S_RDR;
        end else if (last_q) begin
          state_d = pef_pkg::S_TOPRD;
        end else begin
          state_d = pef_pkg::S_IDLE;
        end
      end
      pef_pkg::S_RDR: state_d = pef_pkg::S_RDL;
      pef_pkg::S_RDL: state_d = pef_pkg::S_EXEC;
      pef_pkg::S_EXEC: begin
        if (alu_rsp.done) begin
          state_d = last_q ? pef_pkg::S_TOPRD : pef_pkg::S_IDLE;
        end
      end
      pef_pkg::S_TOPRD: begin
        state_d = (cnt_q == '0) ? pef_pkg::S_EMIT : pef_pkg::S_TOPWT;
      end
      pef_pkg::S_TOPWT: state_d = pef_pkg::S_EMIT;
      pef_pkg::S_EMIT: begin
        if (can_emit) begin
          state_d = pef_pkg::S_IDLE;
        end
      end
      default: state_d = pef_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    err_d       = err_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    accum_d     = accum_q;
    innum_d     = innum_q;
    isop_d      = isop_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    r_d         = r_q;
    top_d       = top_q;
    value_d     = value_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[A-1:0];
    ram_wdata   = accum_q;
    ram_re      = 1'b0;
    ram_raddr   = cnt_m1[A-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    unique case (state_q)
      pef_pkg::S_IDLE: begin
        if (in_valid_i) begin
          last_d = last_char_i;
          if (is_digit) begin
            accum_d = accum_next;
            innum_d = 1'b1;
            isop_d  = 1'b0;
          end else begin
            isop_d = is_op;
            op_d   = op_dec;
          end
        end
      end
      pef_pkg::S_PUSHN: begin
        if (innum_q) begin
          if (cnt_q == FULL_CNT) begin
            if (err_q == pef_pkg::ST_OK) begin
              err_d = pef_pkg::ST_OVER;
            end
          end else begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + C'(1);
          end
          accum_d = '0;
          innum_d = 1'b0;
        end
      end
      pef_pkg::S_OPCHK: begin
        if (cnt_q >= C'(2)) begin
          ram_re = 1'b1;
        end else if (err_q == pef_pkg::ST_OK) begin
          err_d = pef_pkg::ST_UNDER;
        end
      end
      pef_pkg::S_RDR: begin
        r_d       = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = cnt_m2[A-1:0];
      end
      pef_pkg::S_RDL: begin
        cnt_d         = cnt_m2;
        alu_req.start = 1'b1;
      end
      pef_pkg::S_EXEC: begin
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = alu_result;
          cnt_d     = cnt_q + C'(1);
          isop_d    = 1'b0;
          if (alu_rsp.divz && err_q == pef_pkg::ST_OK) begin
            err_d = pef_pkg::ST_DIVZ;
          end
        end
      end
      pef_pkg::S_TOPRD: begin
        if (cnt_q == '0) begin
          top_d = '0;
        end else begin
          ram_re = 1'b1;
        end
      end
      pef_pkg::S_TOPWT: begin
        top_d = ram_rdata;
      end
      pef_pkg::S_EMIT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          value_d     = top_q;
          if (err_q != pef_pkg::ST_OK) begin
            status_d = err_q;
          end else if (cnt_q == '0) begin
            status_d = pef_pkg::ST_UNDER;
          end else begin
            status_d = pef_pkg::ST_OK;
          end
          cnt_d   = '0;
          accum_d = '0;
          innum_d = 1'b0;
          err_d   = pef_pkg::ST_OK;
          isop_d  = 1'b0;
          last_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pef_pkg::S_IDLE;
      op_q        <= pef_pkg::OP_ADD;
      err_q       <= pef_pkg::ST_OK;
      cnt_q       <= '0;
      accum_q     <= '0;
      innum_q     <= 1'b0;
      isop_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      accum_q     <= accum_d;
      innum_q     <= innum_d;
      isop_q      <= isop_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    top_q    <= top_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  pef_ram #(
    .WIDTH(W),
    .DEPTH(pef_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pef_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (ram_rdata),
    .b_i     (r_q),
    .rsp_o   (alu_rsp),
    .result_o(alu_result)
  );

  assign in_stall_o  = (state_q != pef_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(value_q);
  assign status_o    = status_q;

endmodule
